// ===== rtl/core/eqp_pkg.sv =====
// Shared types, constants and helpers for the equirectangular point projection.
// No dependencies; every other file of the block imports this package.
package eqp_pkg;

    // config register indexes
    typedef enum logic [3:0] {
        REG_ROT_X   = 4'd0,
        REG_ROT_Y   = 4'd1,
        REG_ROT_Z   = 4'd2,
        REG_SHIFT_X = 4'd3,
        REG_SHIFT_Y = 4'd4,
        REG_SHIFT_Z = 4'd5,
        REG_WIDTH   = 4'd6,
        REG_HEIGHT  = 4'd7
    } t_cfg_reg;

    localparam int CFG_IW = 4;
    localparam int CFG_DW = 48;

    // CORDIC datapath
    localparam int CORDIC_ITERS = 30;
    localparam int CW           = 34;   // signed x/y width inside the rotators
    localparam int NORM_MSB     = 29;   // normalized magnitude lies in [2^29, 2^30)
    localparam logic [30:0] INV_GAIN = 31'h4DBA76D4;

    // image size limits
    localparam logic [13:0] MAX_WIDTH  = 14'd8192;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // register stages from the accepting edge to the edge that loads the result
    localparam int PIPE_LAT = 72;

    // atan(2^-i) in 2^-32 turns
    localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // control bits that ride along with a point
    typedef struct packed {
        logic vld;
        logic zero;
        logic last;
    } t_ctl;

    // round a turn angle to ab bits (wraps modulo one turn)
    function automatic logic [31:0] angle_code(input logic [31:0] a, input int ab);
        logic [31:0] sum;
        sum = a + (32'd1 << (31 - ab));
        return sum >> (32 - ab);
    endfunction

endpackage

// ===== rtl/core/eqp_xform.sv =====
// Rigid transform: 3x3 Q2.14 rotation plus Q16.16 translation, two stages.
// Depends on eqp_pkg.
module eqp_xform import eqp_pkg::*; #(
    parameter int CB = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic                 i_last,
    input  logic signed [CB-1:0] i_px,
    input  logic signed [CB-1:0] i_py,
    input  logic signed [CB-1:0] i_pz,
    input  logic [47:0]          i_rot_x,
    input  logic [47:0]          i_rot_y,
    input  logic [47:0]          i_rot_z,
    input  logic signed [CB-1:0] i_shift_x,
    input  logic signed [CB-1:0] i_shift_y,
    input  logic signed [CB-1:0] i_shift_z,
    output logic                 o_vld,
    output logic                 o_last,
    output logic signed [CB+4:0] o_q [3]
);

    logic signed [CB-1:0]  coord [3];
    logic [47:0]           rows  [3];
    logic signed [CB-1:0]  shifts[3];
    logic signed [CB+15:0] r_prod [3][3];
    logic                  r_vld1, r_last1;
    logic signed [CB+17:0] acc [3];

    assign coord  = '{i_px, i_py, i_pz};
    assign rows   = '{i_rot_x, i_rot_y, i_rot_z};
    assign shifts = '{i_shift_x, i_shift_y, i_shift_z};

    // stage 1: nine products
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[r][k] <= (CB+16)'(signed'(rows[r][47-16*k -: 16]))
                              * (CB+16)'(coord[k]);
            end
        end
        r_last1 <= i_last;
    end

    // stage 2: row sums, floor by 2^14, add translation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = (CB+18)'(r_prod[r][0]) + (CB+18)'(r_prod[r][1])
                   + (CB+18)'(r_prod[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            o_q[r] <= (CB+5)'(acc[r] >>> 14) + (CB+5)'(shifts[r]);
        end
        o_last <= r_last1;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            o_vld  <= r_vld1;
        end
    end

endmodule

// ===== rtl/core/eqp_norm.sv =====
// Normalizer: scales the three coordinates together so the largest magnitude
// lands in [2^29, 2^30). Four stages. Depends on eqp_pkg.
module eqp_norm import eqp_pkg::*; #(
    parameter int QW = 37
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic                 i_last,
    input  logic signed [QW-1:0] i_q [3],
    output t_ctl                 o_ctl,
    output logic signed [CW-1:0] o_v [3]
);

    localparam int PW = $clog2(QW);
    localparam int NW = QW + 30;

    logic signed [QW-1:0] r_qa [3], r_qb [3], r_qc [3];
    logic [QW-1:0]        r_m [3];
    logic [QW-1:0]        r_mx;
    logic [PW-1:0]        r_pos, pos;
    logic                 r_zero;
    logic [2:0]           r_vld, r_last;
    logic signed [NW-1:0] ext [3];
    logic signed [NW-1:0] sh  [3];

    // stage A: magnitudes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_qa[k] <= i_q[k];
            r_m[k]  <= i_q[k][QW-1] ? QW'(-i_q[k]) : QW'(i_q[k]);
        end
    end

    // stage B: largest magnitude
    always_ff @(posedge i_clk) begin
        r_qb <= r_qa;
        if (r_m[0] >= r_m[1] && r_m[0] >= r_m[2]) begin
            r_mx <= r_m[0];
        end else if (r_m[1] >= r_m[2]) begin
            r_mx <= r_m[1];
        end else begin
            r_mx <= r_m[2];
        end
    end

    // stage C: leading one position
    always_comb begin
        pos = '0;
        for (int i = 0; i < QW; i++) begin
            if (r_mx[i]) pos = PW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_qc   <= r_qb;
        r_pos  <= pos;
        r_zero <= (r_mx == '0);
    end

    // stage D: common shift (right shifts floor)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ext[k] = NW'(r_qc[k]);
            if (int'(r_pos) >= NORM_MSB) begin
                sh[k] = ext[k] >>> (int'(r_pos) - NORM_MSB);
            end else begin
                sh[k] = ext[k] <<< (NORM_MSB - int'(r_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            o_v[k] <= CW'(signed'(sh[k][30:0]));
        end
        o_ctl.zero <= r_zero;
        o_ctl.last <= r_last[2];
    end

    // last flag pipeline
    always_ff @(posedge i_clk) begin
        r_last <= {r_last[1:0], i_last};
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            o_ctl.vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[1:0], i_vld};
            o_ctl.vld <= r_vld[2];
        end
    end

endmodule

// ===== rtl/core/eqp_cordic.sv =====
// Pipelined CORDIC vectoring: prerotation stage plus one stage per iteration.
// Gives the angle of (x,y) in 2^-32 turns and the scaled radius. Depends on eqp_pkg.
module eqp_cordic import eqp_pkg::*; #(
    parameter int SW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic [SW-1:0]        i_side,
    output logic                 o_vld,
    output logic signed [CW-1:0] o_x,
    output logic [31:0]          o_ang,
    output logic [SW-1:0]        o_side
);

    logic signed [CW-1:0] r_x [CORDIC_ITERS+1];
    logic signed [CW-1:0] r_y [CORDIC_ITERS+1];
    logic [31:0]          r_a [CORDIC_ITERS+1];
    logic [SW-1:0]        r_s [CORDIC_ITERS+1];
    logic                 r_v [CORDIC_ITERS+1];

    // prerotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_a[0] <= 32'h80000000;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_a[0] <= '0;
        end
        r_s[0] <= i_side;
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_a[i+1] <= r_a[i] + ATAN_TURNS[i];
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_a[i+1] <= r_a[i] - ATAN_TURNS[i];
            end
            r_s[i+1] <= r_s[i];
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CORDIC_ITERS; i++) r_v[i] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
            for (int i = 0; i < CORDIC_ITERS; i++) r_v[i+1] <= r_v[i];
        end
    end

    assign o_vld  = r_v[CORDIC_ITERS];
    assign o_x    = r_x[CORDIC_ITERS];
    assign o_ang  = r_a[CORDIC_ITERS];
    assign o_side = r_s[CORDIC_ITERS];

endmodule

// ===== rtl/core/eqp_pixel.sv =====
// Pixel mapper: angle codes to column, row and linear index, two stages.
// Depends on eqp_pkg.
module eqp_pixel import eqp_pkg::*; #(
    parameter int AB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [31:0]   i_polar,
    input  logic [AB-1:0] i_pitch,
    input  logic [13:0]   i_width,
    input  logic [12:0]   i_height,
    output logic          o_valid,
    output logic          o_hit,
    output logic [12:0]   o_col,
    output logic [11:0]   o_row,
    output logic [24:0]   o_index,
    output logic          o_last
);

    logic [13:0]    w;
    logic [12:0]    h;
    logic [AB-1:0]  yaw;
    logic           miss;
    logic [AB+13:0] colp;
    logic [AB+12:0] rowp;
    logic [13:0]    r_w;
    logic [12:0]    r_col;
    logic [11:0]    r_row;
    logic           r_hit, r_last, r_vld;
    logic [25:0]    idx;

    // stage 1: clamp size, code the polar angle, scale both angles
    always_comb begin
        w    = (i_width  > MAX_WIDTH)  ? MAX_WIDTH  : i_width;
        h    = (i_height > MAX_HEIGHT) ? MAX_HEIGHT : i_height;
        yaw  = AB'(angle_code(i_polar, AB));
        miss = i_ctl.zero || (w == '0) || (h == '0) || yaw[AB-1];
        colp = (AB+14)'(w) * (AB+14)'(i_pitch);
        rowp = (AB+13)'(h) * (AB+13)'(yaw);
    end

    always_ff @(posedge i_clk) begin
        r_w    <= w;
        r_hit  <= !miss;
        r_col  <= miss ? '0 : colp[AB+12:AB];
        r_row  <= miss ? '0 : rowp[AB+10:AB-1];
        r_last <= i_ctl.last;
    end

    // stage 2: linear index
    assign idx = 26'(r_row) * 26'(r_w) + 26'(r_col);

    always_ff @(posedge i_clk) begin
        o_hit   <= r_hit;
        o_col   <= r_col;
        o_row   <= r_row;
        o_index <= idx[24:0];
        o_last  <= r_last;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= i_ctl.vld;
            o_valid <= r_vld;
        end
    end

endmodule

// ===== rtl/core/equirect_point_projection.sv =====
// Top level of the equirectangular point projection pipeline.
// Depends on eqp_pkg, eqp_xform, eqp_norm, eqp_cordic and eqp_pixel.
//
// Usage:
//   Input channel: drive a point on i_point_x/y/z and i_last_point and raise
//   start; the item is taken at a rising edge with start high and busy low.
//   busy is low whenever reset is released, so one item can be taken every
//   cycle, with no gaps.
//   Result channel: o_valid marks one cycle holding o_hit, o_pixel_col,
//   o_pixel_row, o_pixel_index and o_last_result. The receiver cannot stall.
//   Pipeline: 72 register stages (input register, transform, normalizer, two
//   31-stage CORDIC rotators, radius scaling, pixel mapping).
//   Throughput: one item per cycle, results in input order.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register per
//   cycle; write only while no items are in flight.
//   Reset: synchronous, active low; clears all in-flight items and returns
//   registers to identity rotation, zero shift and a 1024 x 512 image.
module equirect_point_projection import eqp_pkg::*; #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic                         i_last_point,
    input  logic                         i_cfg_we,
    input  logic [CFG_IW-1:0]            i_cfg_idx,
    input  logic [CFG_DW-1:0]            i_cfg_data,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [12:0]                  o_pixel_col,
    output logic [11:0]                  o_pixel_row,
    output logic [24:0]                  o_pixel_index,
    output logic                         o_last_result
);

    localparam int QW  = COORD_BITS + 5;
    localparam int SW1 = CW + 2;
    localparam int SW2 = ANGLE_BITS + 2;

    logic [47:0] r_rot_x, r_rot_y, r_rot_z;
    logic [31:0] r_shift_x, r_shift_y, r_shift_z;
    logic [13:0] r_width;
    logic [12:0] r_height;

    logic                         r_in_vld, r_in_last;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic signed [COORD_BITS-1:0] sh_x, sh_y, sh_z;

    logic                 xf_vld, xf_last;
    logic signed [QW-1:0] xf_q [3];
    t_ctl                 nm_ctl;
    logic signed [CW-1:0] nm_v [3];

    logic                 c1_vld;
    logic signed [CW-1:0] c1_x;
    logic [31:0]          c1_ang;
    logic [SW1-1:0]       c1_side;
    logic [63:0]          rad_prod;

    logic                  r_rd_vld, r_rd_zero, r_rd_last;
    logic [31:0]           r_rad;
    logic signed [CW-1:0]  r_rd_z;
    logic [ANGLE_BITS-1:0] r_pitch;

    logic                 c2_vld;
    logic signed [CW-1:0] c2_x;
    logic [31:0]          c2_ang;
    logic [SW2-1:0]       c2_side;
    t_ctl                 px_ctl;

    assign busy = !i_rst_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x   <= 48'h4000_0000_0000;
            r_rot_y   <= 48'h0000_4000_0000;
            r_rot_z   <= 48'h0000_0000_4000;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
            r_width   <= 14'd1024;
            r_height  <= 13'd512;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ROT_X:   r_rot_x   <= i_cfg_data;
                REG_ROT_Y:   r_rot_y   <= i_cfg_data;
                REG_ROT_Z:   r_rot_z   <= i_cfg_data;
                REG_SHIFT_X: r_shift_x <= i_cfg_data[31:0];
                REG_SHIFT_Y: r_shift_y <= i_cfg_data[31:0];
                REG_SHIFT_Z: r_shift_z <= i_cfg_data[31:0];
                REG_WIDTH:   r_width   <= i_cfg_data[13:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // translation at coordinate width
    if (COORD_BITS <= 32) begin : g_sh_narrow
        assign sh_x = signed'(r_shift_x[COORD_BITS-1:0]);
        assign sh_y = signed'(r_shift_y[COORD_BITS-1:0]);
        assign sh_z = signed'(r_shift_z[COORD_BITS-1:0]);
    end else begin : g_sh_wide
        assign sh_x = signed'({{(COORD_BITS-32){1'b0}}, r_shift_x});
        assign sh_y = signed'({{(COORD_BITS-32){1'b0}}, r_shift_y});
        assign sh_z = signed'({{(COORD_BITS-32){1'b0}}, r_shift_z});
    end

    // input register
    always_ff @(posedge i_clk) begin
        r_px      <= i_point_x;
        r_py      <= i_point_y;
        r_pz      <= i_point_z;
        r_in_last <= i_last_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    eqp_xform #(.CB(COORD_BITS)) u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_in_vld),
        .i_last    (r_in_last),
        .i_px      (r_px),
        .i_py      (r_py),
        .i_pz      (r_pz),
        .i_rot_x   (r_rot_x),
        .i_rot_y   (r_rot_y),
        .i_rot_z   (r_rot_z),
        .i_shift_x (sh_x),
        .i_shift_y (sh_y),
        .i_shift_z (sh_z),
        .o_vld     (xf_vld),
        .o_last    (xf_last),
        .o_q       (xf_q)
    );

    eqp_norm #(.QW(QW)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (xf_vld),
        .i_last  (xf_last),
        .i_q     (xf_q),
        .o_ctl   (nm_ctl),
        .o_v     (nm_v)
    );

    // azimuth rotator; z and flags ride along
    eqp_cordic #(.SW(SW1)) u_cordic_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (nm_ctl.vld),
        .i_x     (nm_v[0]),
        .i_y     (nm_v[1]),
        .i_side  ({nm_v[2], nm_ctl.zero, nm_ctl.last}),
        .o_vld   (c1_vld),
        .o_x     (c1_x),
        .o_ang   (c1_ang),
        .o_side  (c1_side)
    );

    // radius gain correction and pitch code
    assign rad_prod = 64'(unsigned'(c1_x[31:0])) * 64'(INV_GAIN);

    always_ff @(posedge i_clk) begin
        r_rad     <= rad_prod[62:31];
        r_pitch   <= ANGLE_BITS'(angle_code(32'd0 - c1_ang, ANGLE_BITS));
        r_rd_z    <= c1_side[SW1-1:2];
        r_rd_zero <= c1_side[1];
        r_rd_last <= c1_side[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= c1_vld;
        end
    end

    // polar rotator
    eqp_cordic #(.SW(SW2)) u_cordic_pol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_x     (r_rd_z),
        .i_y     (signed'(CW'(r_rad))),
        .i_side  ({r_pitch, r_rd_zero, r_rd_last}),
        .o_vld   (c2_vld),
        .o_x     (c2_x),
        .o_ang   (c2_ang),
        .o_side  (c2_side)
    );

    assign px_ctl.vld  = c2_vld && (c2_x == c2_x);
    assign px_ctl.zero = c2_side[1];
    assign px_ctl.last = c2_side[0];

    eqp_pixel #(.AB(ANGLE_BITS)) u_pixel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (px_ctl),
        .i_polar  (c2_ang),
        .i_pitch  (c2_side[SW2-1:2]),
        .i_width  (r_width),
        .i_height (r_height),
        .o_valid  (o_valid),
        .o_hit    (o_hit),
        .o_col    (o_pixel_col),
        .o_row    (o_pixel_row),
        .o_index  (o_pixel_index),
        .o_last   (o_last_result)
    );

endmodule

// ===== rtl/core/eqp_chk.sv =====
// Port-level checker for the projection pipeline, bound to the top level.
// Depends on eqp_pkg for the pipeline latency.
module eqp_chk import eqp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last_point,
    input logic        o_valid,
    input logic        o_hit,
    input logic [12:0] o_pixel_col,
    input logic [11:0] o_pixel_row,
    input logic [24:0] o_pixel_index,
    input logic        o_last_result
);

    logic [6:0] r_warm;

    // cycles since reset, saturating at the latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != 7'(PIPE_LAT)) begin
            r_warm <= r_warm + 7'd1;
        end
    end

    // every accepted item gives exactly one result, a fixed latency later
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == 7'(PIPE_LAT)) |-> (o_valid == $past(start && !busy, PIPE_LAT)))
        else $error("result strobe does not match an accepted item");

    // the last flag follows its own item
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == 7'(PIPE_LAT) && o_valid) |-> (o_last_result == $past(i_last_point, PIPE_LAT)))
        else $error("last flag out of order");

    // a miss carries zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_pixel_col == '0 && o_pixel_row == '0 && o_pixel_index == '0))
        else $error("miss with nonzero pixel");

    // reset flushes all items
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind equirect_point_projection eqp_chk u_eqp_chk (.*);

// ===== test/equirect_point_projection_test.sv =====
// Self-checking testbench for equirect_point_projection.
// Depends on eqp_pkg and the block's RTL; a built-in predictor computes each pixel result.
`timescale 1ns / 1ps

module equirect_point_projection_test;
    import eqp_pkg::*;

    // no register sits at this index; writes to it must be ignored
    localparam logic [CFG_IW-1:0] UNUSED_REG = 4'hF;

    typedef struct {
        bit          hit;
        logic [12:0] col;
        logic [11:0] row;
        logic [24:0] index;
        bit          last;
    } t_pixel;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic signed [31:0] i_point_x, i_point_y, i_point_z;
    logic              i_last_point;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;
    logic              o_valid, o_hit, o_last_result;
    logic [12:0]       o_pixel_col;
    logic [11:0]       o_pixel_row;
    logic [24:0]       o_pixel_index;

    // predictor copy of the register file
    logic [47:0] rot_row [3];
    logic [31:0] shift_reg [3];
    logic [13:0] width_reg;
    logic [12:0] height_reg;

    t_pixel pending_pixels[$];
    int     error_count;
    int     point_count;
    int     hit_count;
    int     result_count;
    bit     no_gaps;

    equirect_point_projection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_last_point(i_last_point), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_hit(o_hit),
        .o_pixel_col(o_pixel_col), .o_pixel_row(o_pixel_row),
        .o_pixel_index(o_pixel_index), .o_last_result(o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("equirect_point_projection verification failed");
        $finish;
    end

    // one transformed coordinate: floor(row . p / 2^14) + shift
    function automatic longint rotate_row(input logic [47:0] row, input longint p[3],
                                          input logic [31:0] sh);
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++)
            acc += longint'($signed(row[47-16*k -: 16])) * p[k];
        return (acc >>> 14) + longint'($signed(sh));
    endfunction

    // CORDIC vectoring: angle in 2^-32 turns, returns the scaled radius
    function automatic longint vector_angle(input longint x, input longint y,
                                            output logic [31:0] ang);
        longint dx, dy;
        ang = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                ang += ATAN_TURNS[i];
            end else begin
                x -= dx;
                y += dy;
                ang -= ATAN_TURNS[i];
            end
        end
        return x;
    endfunction

    function automatic logic [15:0] round_turn(input logic [31:0] a);
        logic [31:0] s;
        s = a + (32'd1 << 15);
        return s[31:16];
    endfunction

    function automatic t_pixel project_point(input logic [31:0] px, py, pz, input bit last);
        t_pixel r;
        longint p[3], q[3];
        longint unsigned m, mg, radius, w, h, col, row;
        logic [31:0] az, polar;
        logic [15:0] pitch, yaw;
        int s;
        r = '{hit: 0, col: '0, row: '0, index: '0, last: last};
        p[0] = longint'($signed(px));
        p[1] = longint'($signed(py));
        p[2] = longint'($signed(pz));
        for (int k = 0; k < 3; k++)
            q[k] = rotate_row(rot_row[k], p, shift_reg[k]);
        m = 0;
        for (int k = 0; k < 3; k++) begin
            mg = q[k] < 0 ? -q[k] : q[k];
            if (mg > m) m = mg;
        end
        if (m == 0) return r;
        // bring the largest magnitude into [2^29, 2^30)
        s = 0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        if (s > 0) begin
            for (int k = 0; k < 3; k++) q[k] = q[k] >>> s;
        end else begin
            while ((m << s) < (64'd1 << 29)) s++;
            for (int k = 0; k < 3; k++) q[k] = q[k] << s;
        end
        radius = vector_angle(q[0], q[1], az);
        pitch  = round_turn(32'd0 - az);
        radius = (radius * 64'h4DBA76D4) >> 31;
        void'(vector_angle(q[2], longint'(radius), polar));
        yaw = round_turn(polar);
        w = width_reg > 14'd8192 ? 8192 : width_reg;
        h = height_reg > 13'd4096 ? 4096 : height_reg;
        if (w == 0 || h == 0 || yaw[15]) return r;
        col = (w * pitch) >> 16;
        row = (h * yaw) >> 15;
        r.hit   = 1;
        r.col   = col[12:0];
        r.row   = row[11:0];
        r.index = 25'(row * w + col);
        return r;
    endfunction

    // result checker: every strobe is matched to the oldest pending pixel
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (pending_pixels.size() == 0) begin
                $error("result with no point pending");
                error_count++;
            end else begin
                e = pending_pixels.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, o_hit); error_count++;
                end
                if (o_pixel_col !== e.col) begin
                    $error("pixel_col: expected %0d, got %0d", e.col, o_pixel_col);
                    error_count++;
                end
                if (o_pixel_row !== e.row) begin
                    $error("pixel_row: expected %0d, got %0d", e.row, o_pixel_row);
                    error_count++;
                end
                if (o_pixel_index !== e.index) begin
                    $error("pixel_index: expected %0d, got %0d", e.index, o_pixel_index);
                    error_count++;
                end
                if (o_last_result !== e.last) begin
                    $error("last_result: expected %0d, got %0d", e.last, o_last_result);
                    error_count++;
                end
            end
        end
    end

    // send one point; called and returns at a falling edge
    task automatic send_point(input logic [31:0] px, py, pz, input bit last);
        bit was_busy;
        t_pixel e;
        int gap;
        i_point_x    <= px;
        i_point_y    <= py;
        i_point_z    <= pz;
        i_last_point <= last;
        start        <= 1'b1;
        do begin
            was_busy = busy;
            @(negedge i_clk);
        end while (was_busy);
        e = project_point(px, py, pz, last);
        pending_pixels.push_back(e);
        point_count++;
        if (e.hit) hit_count++;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_pixels.size() != 0) @(negedge i_clk);
    endtask

    // register write, only while the pipeline is empty
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [47:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROT_X:   rot_row[0]    = data;
            REG_ROT_Y:   rot_row[1]    = data;
            REG_ROT_Z:   rot_row[2]    = data;
            REG_SHIFT_X: shift_reg[0]  = data[31:0];
            REG_SHIFT_Y: shift_reg[1]  = data[31:0];
            REG_SHIFT_Z: shift_reg[2]  = data[31:0];
            REG_WIDTH:   width_reg     = data[13:0];
            REG_HEIGHT:  height_reg    = data[12:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'h4000;
            2: return 16'hC000;
            default: return 16'($signed($urandom_range(0, 32'h8000)) - 32'h4000);
        endcase
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1));
    endtask

    // axes, extremes, origin, straight down, pitch wrap, last flag
    task automatic test_directed_points();
        send_point(0, 0, 0, 1);                              // origin: miss
        send_point(32'h0001_0000, 0, 0, 0);
        send_point(0, 32'h0001_0000, 0, 0);
        send_point(0, 32'hFFFF_0000, 0, 1);
        send_point(32'hFFFF_0000, 0, 0, 0);
        send_point(0, 0, 32'h0001_0000, 0);                  // straight up
        send_point(0, 0, 32'hFFFF_0000, 1);                  // polar half turn: miss
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send_point(1, 0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);      // azimuth just below zero
        send_point(32'h7FFF_FFFF, 1, 0, 0);                  // pitch near a full turn
        send_point(1, 1, 1, 1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_point(0, 0, 32'h8000_0000, 1);
        drain();
    endtask

    task automatic test_default_config();
        send_random(400);
        no_gaps = 1;
        send_random(100);
        no_gaps = 0;
        drain();
    endtask

    task automatic test_image_sizes();
        logic [13:0] widths [6]  = '{14'd0, 14'd1, 14'd8192, 14'h3FFF, 14'd640, 14'd1};
        logic [12:0] heights [6] = '{13'd5, 13'd0, 13'd4096, 13'h1FFF, 13'd1, 13'd480};
        for (int k = 0; k < 6; k++) begin
            write_reg(REG_WIDTH, 48'(widths[k]));
            write_reg(REG_HEIGHT, 48'(heights[k]));
            send_point(0, 0, 0, 0);
            send_point(0, 0, 32'hFFFF_0000, 0);
            send_random(60);
            drain();
        end
        write_reg(REG_WIDTH, 48'd8192);
        write_reg(REG_HEIGHT, 48'd4096);
    endtask

    task automatic test_transforms();
        for (int k = 0; k < 8; k++) begin
            write_reg(REG_ROT_X, {rand_coef(), rand_coef(), rand_coef()});
            write_reg(REG_ROT_Y, {rand_coef(), rand_coef(), rand_coef()});
            write_reg(REG_ROT_Z, {rand_coef(), rand_coef(), rand_coef()});
            write_reg(REG_SHIFT_X, 48'(rand_coord()));
            write_reg(REG_SHIFT_Y, 48'(rand_coord()));
            write_reg(REG_SHIFT_Z, 48'(rand_coord()));
            no_gaps = (k == 3);
            send_random(50);
            no_gaps = 0;
            drain();
        end
        // extreme coefficients and shifts
        write_reg(REG_ROT_X, 48'h7FFF_8000_7FFF);
        write_reg(REG_ROT_Y, 48'h8000_8000_8000);
        write_reg(REG_ROT_Z, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SHIFT_X, 48'h7FFF_FFFF);
        write_reg(REG_SHIFT_Y, 48'h8000_0000);
        write_reg(REG_SHIFT_Z, 48'h0);
        send_random(60);
        drain();
        // identity with a shift that cancels the point: transformed origin
        write_reg(REG_ROT_X, 48'h4000_0000_0000);
        write_reg(REG_ROT_Y, 48'h0000_4000_0000);
        write_reg(REG_ROT_Z, 48'h0000_0000_4000);
        write_reg(REG_SHIFT_X, 48'hFFFF_0000);
        write_reg(REG_SHIFT_Y, 48'h0002_0000);
        write_reg(REG_SHIFT_Z, 48'h0);
        send_point(32'h0001_0000, 32'hFFFE_0000, 0, 1);
        send_random(40);
        drain();
    endtask

    // a write to an unmapped index must leave every register alone
    task automatic test_unused_register();
        write_reg(UNUSED_REG, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SHIFT_X, 48'h0);
        write_reg(REG_SHIFT_Y, 48'h0);
        write_reg(REG_WIDTH, 48'd1024);
        write_reg(REG_HEIGHT, 48'd512);
        send_random(100);
        drain();
    endtask

    initial begin
        error_count = 0; point_count = 0; hit_count = 0; result_count = 0; no_gaps = 0;
        rot_row[0] = 48'h4000_0000_0000;
        rot_row[1] = 48'h0000_4000_0000;
        rot_row[2] = 48'h0000_0000_4000;
        shift_reg[0] = '0; shift_reg[1] = '0; shift_reg[2] = '0;
        width_reg = 14'd1024;
        height_reg = 13'd512;
        i_rst_n = 1'b0; start = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0; i_last_point = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_points();
        test_default_config();
        test_image_sizes();
        test_transforms();
        test_unused_register();

        // let any stray strobe show up
        repeat (PIPE_LAT + 20) @(negedge i_clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d results never arrived", pending_pixels.size());
            error_count++;
        end
        $display("Projected %0d points (%0d inside the panorama), %0d results checked,",
                 point_count, hit_count, result_count);
        $display("over default, resized and transformed register settings.");
        if (error_count == 0)
            $display("equirect_point_projection verification clean");
        else
            $display("equirect_point_projection verification failed");
        $finish;
    end

endmodule
